>>> rtl/core/multi_led_blink_controller_defines.svh
// Assertion macros shared by the blink controller checker
`ifndef MULTI_LED_BLINK_CONTROLLER_DEFINES_SVH
`define MULTI_LED_BLINK_CONTROLLER_DEFINES_SVH

// Check a same-cycle implication outside reset
`define MLBC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a next-cycle implication outside reset
`define MLBC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check a next-cycle implication that covers reset itself
`define MLBC_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mlbc_pkg.sv
// Shared types, constants and helpers of the multi-LED blink controller
`default_nettype none

package mlbc_pkg;

  localparam int NUM_LEDS   = 6;
  localparam int LED_W      = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int IDX_W      = 4;
  localparam int VIS_LEDS   = (NUM_LEDS < 6) ? NUM_LEDS : 6;
  localparam int LEVELS_W   = 6;
  localparam int IVL_W      = 16;
  localparam int CNT_W      = 16;
  localparam int TGL_W      = 17;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int RESQ_DEPTH = 2;
  localparam int RESQ_PTR_W = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
  localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

  // Input kind codes
  typedef enum logic [2:0] {
    KIND_TICK         = 3'd0,
    KIND_SET          = 3'd1,
    KIND_TOGGLE       = 3'd2,
    KIND_BLINK_ON     = 3'd3,
    KIND_BLINK_OFF    = 3'd4,
    KIND_BLINK_TOGGLE = 3'd5,
    KIND_BLINK_TIMES  = 3'd6
  } kind_t;

  // Decoded operations handed from front to back
  typedef enum logic [2:0] {
    OP_NOP          = 3'd0,
    OP_TICK         = 3'd1,
    OP_SET          = 3'd2,
    OP_TOGGLE       = 3'd3,
    OP_START        = 3'd4,
    OP_STOP         = 3'd5,
    OP_BLINK_TOGGLE = 3'd6
  } op_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [IDX_W-1:0] led_index;
    logic             level;
    logic [IVL_W-1:0] interval;
    logic [CNT_W-1:0] repeat_count;
  } item_t;

  typedef struct packed {
    logic [LEVELS_W-1:0] led_levels;
    logic                accepted;
  } res_t;

  typedef struct packed {
    op_t              op;
    logic [LED_W-1:0] led;
    logic             level;
    logic             endless;
    logic [IVL_W-1:0] interval;
    logic [TGL_W-1:0] toggles;
    logic             accepted;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Steady level after reset: on for even LEDs, off for odd ones
  function automatic logic [NUM_LEDS-1:0] steady_reset();
    logic [NUM_LEDS-1:0] v;
    for (int i = 0; i < NUM_LEDS; i++) begin
      v[i] = (i % 2 == 0);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/mlbc_front.sv
// Front stage: decode and validate input beats into commands
`default_nettype none

module mlbc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  mlbc_pkg::item_t in_item,
  output logic            cmd_valid,
  output mlbc_pkg::cmd_t  cmd,
  input  mlbc_pkg::q_stat_t q_stat
);
  import mlbc_pkg::*;

  logic  valid_r;
  cmd_t  cmd_r;
  cmd_t  dec;
  logic  take;
  logic  idx_ok;
  logic  ivl_ok;
  logic  cnt_ok;

  assign full      = valid_r & q_stat.full;
  assign take      = push & ~full;
  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

  // Classify the beat and check its LED, interval and count
  assign idx_ok = ({1'b0, in_item.led_index} < (IDX_W + 1)'(NUM_LEDS));
  assign ivl_ok = |in_item.interval;
  assign cnt_ok = |in_item.repeat_count;

  always_comb begin
    dec          = '0;
    dec.op       = OP_NOP;
    dec.led      = in_item.led_index[LED_W-1:0];
    dec.level    = in_item.level;
    dec.endless  = 1'b1;
    dec.interval = in_item.interval;
    dec.toggles  = '0;
    dec.accepted = 1'b0;
    case (in_item.kind)
      KIND_TICK: begin
        dec.op       = OP_TICK;
        dec.accepted = 1'b1;
      end
      KIND_SET: begin
        if (idx_ok) begin
          dec.op       = OP_SET;
          dec.accepted = 1'b1;
        end
      end
      KIND_TOGGLE: begin
        if (idx_ok) begin
          dec.op       = OP_TOGGLE;
          dec.accepted = 1'b1;
        end
      end
      KIND_BLINK_ON: begin
        if (idx_ok && ivl_ok) begin
          dec.op       = OP_START;
          dec.accepted = 1'b1;
        end
      end
      KIND_BLINK_OFF: begin
        if (idx_ok) begin
          dec.op       = OP_STOP;
          dec.accepted = 1'b1;
        end
      end
      KIND_BLINK_TOGGLE: begin
        if (idx_ok && ivl_ok) begin
          dec.op       = OP_BLINK_TOGGLE;
          dec.accepted = 1'b1;
        end
      end
      KIND_BLINK_TIMES: begin
        if (idx_ok && ivl_ok && cnt_ok) begin
          dec.op       = OP_START;
          dec.endless  = 1'b0;
          dec.toggles  = {in_item.repeat_count, 1'b0} - TGL_W'(1);
          dec.accepted = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Hold the decoded beat until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (!q_stat.full) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= dec;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mlbc_cmd_q.sv
// Short command queue between the front and back stages
`default_nettype none

module mlbc_cmd_q (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  input  mlbc_pkg::cmd_t    wr_cmd,
  output mlbc_pkg::q_stat_t q_stat,
  input  logic              rd_en,
  output mlbc_pkg::cmd_t    rd_cmd
);
  import mlbc_pkg::*;

  cmd_t                  ent_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r;
  logic [CMDQ_CNT_W-1:0] cnt_r;
  logic                  wr;
  logic                  rd;

  assign q_stat.full  = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign wr           = wr_valid & ~q_stat.full;
  assign rd           = rd_en & ~q_stat.empty;
  assign rd_cmd       = ent_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= (wr_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd) begin
        rd_ptr_r <= (rd_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (wr) begin
      ent_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mlbc_back.sv
// Back stage: per-LED blink state, command execution and result queue
`default_nettype none

module mlbc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mlbc_pkg::cmd_t    cmd,
  input  mlbc_pkg::q_stat_t q_stat,
  output logic              cmd_pop,
  output logic              empty,
  input  logic              pop,
  output mlbc_pkg::res_t    out_result
);
  import mlbc_pkg::*;

  logic [NUM_LEDS-1:0] steady_r,  steady_nxt;
  logic [NUM_LEDS-1:0] active_r,  active_nxt;
  logic [NUM_LEDS-1:0] forever_r, forever_nxt;
  logic [NUM_LEDS-1:0] restore_r, restore_nxt;
  logic [NUM_LEDS-1:0] output_r,  output_nxt;
  logic [IVL_W-1:0]    interval_r [NUM_LEDS];
  logic [IVL_W-1:0]    interval_nxt [NUM_LEDS];
  logic [IVL_W-1:0]    elapsed_r [NUM_LEDS];
  logic [IVL_W-1:0]    elapsed_nxt [NUM_LEDS];
  logic [TGL_W-1:0]    toggles_r [NUM_LEDS];
  logic [TGL_W-1:0]    toggles_nxt [NUM_LEDS];

  logic [IVL_W-1:0]    el_inc [NUM_LEDS];
  logic [TGL_W-1:0]    tg_dec [NUM_LEDS];
  logic [NUM_LEDS-1:0] hit;
  logic [LEVELS_W-1:0] levels;
  res_t                res;

  res_t                  res_r [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0] res_wr_ptr_r;
  logic [RESQ_PTR_W-1:0] res_rd_ptr_r;
  logic [RESQ_CNT_W-1:0] res_cnt_r;
  logic                  res_full;
  logic                  fire;
  logic                  res_rd;

  assign res_full   = (res_cnt_r == RESQ_CNT_W'(RESQ_DEPTH));
  assign empty      = (res_cnt_r == '0);
  assign fire       = ~q_stat.empty & ~res_full;
  assign cmd_pop    = fire;
  assign res_rd     = pop & ~empty;
  assign out_result = res_r[res_rd_ptr_r];

  // Per-LED increments and target match
  always_comb begin
    for (int i = 0; i < NUM_LEDS; i++) begin
      el_inc[i] = elapsed_r[i] + IVL_W'(1);
      tg_dec[i] = toggles_r[i] - TGL_W'(1);
      hit[i]    = (cmd.led == LED_W'(i));
    end
  end

  // Apply the command to every LED in parallel
  always_comb begin
    steady_nxt   = steady_r;
    active_nxt   = active_r;
    forever_nxt  = forever_r;
    restore_nxt  = restore_r;
    output_nxt   = output_r;
    interval_nxt = interval_r;
    elapsed_nxt  = elapsed_r;
    toggles_nxt  = toggles_r;
    for (int i = 0; i < NUM_LEDS; i++) begin
      case (cmd.op)
        OP_TICK: begin
          if (active_r[i]) begin
            if (el_inc[i] < interval_r[i]) begin
              elapsed_nxt[i] = el_inc[i];
            end else begin
              elapsed_nxt[i] = '0;
              output_nxt[i]  = ~output_r[i];
              if (!forever_r[i]) begin
                toggles_nxt[i] = tg_dec[i];
                if (tg_dec[i] == '0) begin
                  active_nxt[i] = 1'b0;
                  output_nxt[i] = restore_r[i];
                end
              end
            end
          end
        end
        OP_SET: begin
          if (hit[i]) begin
            active_nxt[i] = 1'b0;
            steady_nxt[i] = cmd.level;
          end
        end
        OP_TOGGLE: begin
          if (hit[i]) begin
            active_nxt[i] = 1'b0;
            steady_nxt[i] = ~steady_r[i];
          end
        end
        OP_STOP: begin
          if (hit[i]) begin
            active_nxt[i] = 1'b0;
          end
        end
        OP_START, OP_BLINK_TOGGLE: begin
          if (hit[i]) begin
            if (cmd.op == OP_BLINK_TOGGLE && active_r[i]) begin
              active_nxt[i] = 1'b0;
            end else begin
              active_nxt[i]   = 1'b1;
              forever_nxt[i]  = cmd.endless;
              restore_nxt[i]  = steady_r[i];
              output_nxt[i]   = ~steady_r[i];
              interval_nxt[i] = cmd.interval;
              elapsed_nxt[i]  = '0;
              toggles_nxt[i]  = cmd.toggles;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Report the driven level of the visible LEDs after the update
  always_comb begin
    levels = '0;
    for (int i = 0; i < VIS_LEDS; i++) begin
      levels[i] = active_nxt[i] ? output_nxt[i] : steady_nxt[i];
    end
    res.led_levels = levels;
    res.accepted   = cmd.accepted;
  end

  // Commit LED state on each executed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steady_r  <= steady_reset();
      active_r  <= '0;
      forever_r <= '0;
      restore_r <= '0;
      output_r  <= '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        interval_r[i] <= '0;
        elapsed_r[i]  <= '0;
        toggles_r[i]  <= '0;
      end
    end else if (fire) begin
      steady_r   <= steady_nxt;
      active_r   <= active_nxt;
      forever_r  <= forever_nxt;
      restore_r  <= restore_nxt;
      output_r   <= output_nxt;
      interval_r <= interval_nxt;
      elapsed_r  <= elapsed_nxt;
      toggles_r  <= toggles_nxt;
    end
  end

  // Advance result queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_ptr_r <= '0;
      res_rd_ptr_r <= '0;
      res_cnt_r    <= '0;
    end else begin
      if (fire) begin
        res_wr_ptr_r <= (res_wr_ptr_r == RESQ_PTR_W'(RESQ_DEPTH - 1)) ?
                        '0 : res_wr_ptr_r + 1'b1;
      end
      if (res_rd) begin
        res_rd_ptr_r <= (res_rd_ptr_r == RESQ_PTR_W'(RESQ_DEPTH - 1)) ?
                        '0 : res_rd_ptr_r + 1'b1;
      end
      if (fire && !res_rd) begin
        res_cnt_r <= res_cnt_r + 1'b1;
      end else if (res_rd && !fire) begin
        res_cnt_r <= res_cnt_r - 1'b1;
      end
    end
  end

  // Store the result beat
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r[res_wr_ptr_r] <= res;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/multi_led_blink_controller.sv
// Top level of the multi-LED blink controller
//
//  Channel  | Ports                   | Accepted when
//  ---------+-------------------------+---------------------
//  input    | push, full, in_item     | push && !full
//  result   | empty, pop, out_result  | pop && !empty
//
// One beat per cycle sustained while full stays low; all LED counters update in parallel.
// A beat's result reaches the result queue after passing the front register (loaded at the
// accepting edge), the command queue and the back stage execute.
// Synchronous active-low reset; LEDs come up on for even, off for odd indexes.
// full rises only when the two-entry result queue and the command queue back up.
`default_nettype none

module multi_led_blink_controller (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  mlbc_pkg::item_t in_item,
  output logic            empty,
  input  logic            pop,
  output mlbc_pkg::res_t  out_result
);
  import mlbc_pkg::*;

  logic    fr_valid;
  cmd_t    fr_cmd;
  q_stat_t q_stat;
  logic    q_pop;
  cmd_t    q_cmd;

  // Decode and validate incoming beats
  mlbc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cmd_valid (fr_valid),
    .cmd       (fr_cmd),
    .q_stat    (q_stat)
  );

  // Decouple front and back
  mlbc_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_cmd   (fr_cmd),
    .q_stat   (q_stat),
    .rd_en    (q_pop),
    .rd_cmd   (q_cmd)
  );

  // Execute commands against LED state
  mlbc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (q_cmd),
    .q_stat     (q_stat),
    .cmd_pop    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_result (out_result)
  );

endmodule

`default_nettype wire

>>> rtl/core/mlbc_checker.sv
// Port-level checker for the multi-LED blink controller, with its bind
`default_nettype none
`include "multi_led_blink_controller_defines.svh"

module mlbc_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            push,
  input wire logic            full,
  input wire logic            empty,
  input wire logic            pop,
  input wire mlbc_pkg::res_t  out_result
);

  // Reset leaves both queues drained
  `MLBC_ASSERT_RST(a_reset_clear, !rst_n, empty && !full, "queues not clear after reset")

  // Back pressure on input only while results wait
  `MLBC_ASSERT_IMP(a_full_has_result, push && full, !empty, "full while no result waits")

  // A waiting result stays until popped
  `MLBC_ASSERT_NXT(a_result_held, !empty && !pop, !empty, "waiting result lost")

  // A waiting result keeps its value until popped
  `MLBC_ASSERT_NXT(a_result_stable, !empty && !pop, $stable(out_result),
                   "waiting result changed")

endmodule

bind multi_led_blink_controller mlbc_checker u_mlbc_checker (.*);

`default_nettype wire

>>> sim/tb_top.sv
// Testbench for the multi-LED blink controller: directed and random beats with a scoreboard
`timescale 1ns / 1ps

module tb_top;
  import mlbc_pkg::*;

  // Kind code with no operation behind it
  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam int PHASE_BEATS = 484;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  push = 1'b0;
  logic  full;
  item_t in_item = '0;
  logic  empty;
  logic  pop = 1'b0;
  res_t  out_result;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // Shadow of the LED state; predicts the level word and accept flag of every beat
  class led_scoreboard;
    bit          steady [NUM_LEDS];
    bit          active [NUM_LEDS];
    bit          forever_job [NUM_LEDS];
    bit          restore [NUM_LEDS];
    bit          blink_out [NUM_LEDS];
    logic [15:0] period [NUM_LEDS];
    logic [15:0] elapsed [NUM_LEDS];
    logic [16:0] toggles_left [NUM_LEDS];
    res_t        pending_levels[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned rejected;
    int unsigned kind_seen [8];

    function new();
      for (int i = 0; i < NUM_LEDS; i++) begin
        steady[i]       = (i % 2 == 0);
        active[i]       = 1'b0;
        forever_job[i]  = 1'b0;
        restore[i]      = 1'b0;
        blink_out[i]    = 1'b0;
        period[i]       = '0;
        elapsed[i]      = '0;
        toggles_left[i] = '0;
      end
      mismatches = 0;
      checked    = 0;
      rejected   = 0;
      for (int k = 0; k < 8; k++) kind_seen[k] = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%t: mismatch: %s", $realtime, msg);
    endfunction

    // Start a job from the inverted steady level
    function void launch_blink(int n, logic [15:0] ivl, bit endless, logic [16:0] toggles);
      active[n]       = 1'b1;
      forever_job[n]  = endless;
      restore[n]      = steady[n];
      blink_out[n]    = ~steady[n];
      period[n]       = ivl;
      elapsed[n]      = '0;
      toggles_left[n] = toggles;
    endfunction

    // Advance every running job by one tick
    function void advance_tick();
      for (int i = 0; i < NUM_LEDS; i++) begin
        if (active[i]) begin
          elapsed[i] = elapsed[i] + 16'd1;
          if (elapsed[i] >= period[i]) begin
            elapsed[i]   = '0;
            blink_out[i] = ~blink_out[i];
            if (!forever_job[i]) begin
              toggles_left[i] = toggles_left[i] - 17'd1;
              if (toggles_left[i] == '0) begin
                active[i]    = 1'b0;
                blink_out[i] = restore[i];
              end
            end
          end
        end
      end
    endfunction

    function logic [LEVELS_W-1:0] driven();
      logic [LEVELS_W-1:0] v;
      v = '0;
      for (int i = 0; i < NUM_LEDS && i < 6; i++) v[i] = active[i] ? blink_out[i] : steady[i];
      return v;
    endfunction

    // Apply one accepted beat and queue its result; return the accept flag
    function bit note_item(item_t it);
      bit   ok;
      bit   valid;
      int   n;
      res_t want;
      ok    = 1'b0;
      valid = (it.led_index < NUM_LEDS);
      n     = valid ? int'(it.led_index) : 0;
      kind_seen[it.kind]++;
      case (it.kind)
        KIND_TICK: begin
          advance_tick();
          ok = 1'b1;
        end
        KIND_SET: if (valid) begin
          active[n] = 1'b0;
          steady[n] = it.level;
          ok = 1'b1;
        end
        KIND_TOGGLE: if (valid) begin
          active[n] = 1'b0;
          steady[n] = ~steady[n];
          ok = 1'b1;
        end
        KIND_BLINK_ON: if (valid && it.interval != 0) begin
          launch_blink(n, it.interval, 1'b1, '0);
          ok = 1'b1;
        end
        KIND_BLINK_OFF: if (valid) begin
          active[n] = 1'b0;
          ok = 1'b1;
        end
        KIND_BLINK_TOGGLE: if (valid && it.interval != 0) begin
          if (active[n]) active[n] = 1'b0;
          else launch_blink(n, it.interval, 1'b1, '0);
          ok = 1'b1;
        end
        KIND_BLINK_TIMES: if (valid && it.interval != 0 && it.repeat_count != 0) begin
          launch_blink(n, it.interval, 1'b0, {it.repeat_count, 1'b0} - 17'd1);
          ok = 1'b1;
        end
        default: ;
      endcase
      if (!ok) rejected++;
      want.led_levels = driven();
      want.accepted   = ok;
      pending_levels.push_back(want);
      return ok;
    endfunction

    // Compare one popped result with the oldest expectation
    function void check_result(res_t got);
      res_t want;
      if (pending_levels.size() == 0) begin
        flag($sformatf("result levels=%b accepted=%b with nothing expected",
                       got.led_levels, got.accepted));
      end else begin
        want = pending_levels.pop_front();
        checked++;
        if (got.led_levels !== want.led_levels || got.accepted !== want.accepted)
          flag($sformatf("levels exp %b got %b, accepted exp %b got %b",
                         want.led_levels, got.led_levels, want.accepted, got.accepted));
      end
    endfunction
  endclass

  led_scoreboard board;

  multi_led_blink_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_result (out_result)
  );

  always #5 clk = ~clk;

  // Stall the result side at random
  always @(negedge clk) begin
    pop <= rst_n && (rx_idle_pct == 0 || $urandom_range(99) >= rx_idle_pct);
  end

  // Check every result beat
  always @(posedge clk) begin
    if (rst_n && pop && !empty) board.check_result(out_result);
  end

  function automatic item_t make_item(logic [2:0] kind, logic [3:0] idx, logic lvl,
                                      logic [15:0] ivl, logic [15:0] cnt);
    item_t it;
    it.kind         = kind;
    it.led_index    = idx;
    it.level        = lvl;
    it.interval     = ivl;
    it.repeat_count = cnt;
    return it;
  endfunction

  // Mostly ticks and valid commands with short intervals so jobs run to completion
  function automatic item_t random_item();
    int          r;
    logic [2:0]  kind;
    logic [3:0]  idx;
    logic [15:0] ivl;
    logic [15:0] cnt;
    r = $urandom_range(99);
    if (r < 45)      kind = KIND_TICK;
    else if (r < 53) kind = KIND_SET;
    else if (r < 59) kind = KIND_TOGGLE;
    else if (r < 69) kind = KIND_BLINK_ON;
    else if (r < 76) kind = KIND_BLINK_OFF;
    else if (r < 86) kind = KIND_BLINK_TOGGLE;
    else if (r < 98) kind = KIND_BLINK_TIMES;
    else             kind = KIND_UNUSED;
    idx = ($urandom_range(99) < 88) ? 4'($urandom_range(NUM_LEDS - 1))
                                    : 4'($urandom_range(15, NUM_LEDS));
    r = $urandom_range(99);
    if (r < 70)      ivl = 16'($urandom_range(3, 1));
    else if (r < 90) ivl = 16'($urandom_range(8, 4));
    else if (r < 95) ivl = '0;
    else             ivl = 16'($urandom_range(65535));
    r = $urandom_range(99);
    if (r < 70)      cnt = 16'($urandom_range(4, 1));
    else if (r < 80) cnt = '0;
    else if (r < 90) cnt = 16'($urandom_range(20, 5));
    else             cnt = 16'($urandom_range(65535));
    return make_item(kind, idx, 1'($urandom_range(1)), ivl, cnt);
  endfunction

  // Offer one beat, hold it until taken, return its accept flag
  task automatic send_item(input item_t it, output bit ok);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push    = 1'b1;
    in_item = it;
    do @(posedge clk); while (full);
    ok = board.note_item(it);
    @(negedge clk);
  endtask

  // Hold the sender until every expected result is out
  task automatic hold_until_drained();
    push = 1'b0;
    while (board.pending_levels.size() != 0) @(negedge clk);
  endtask

  initial begin
    item_t directed[$];
    bit    ok;
    int    taken;
    board = new();

    // Reset levels, set and toggle, blink start and stop, counted jobs, rejects
    directed.push_back(make_item(KIND_TICK, 4'd0, 1'b0, 16'd0, 16'd0));
    directed.push_back(make_item(KIND_SET, 4'd0, 1'b0, 16'd0, 16'd0));
    directed.push_back(make_item(KIND_SET, 4'd5, 1'b1, 16'hFFFF, 16'hFFFF));
    directed.push_back(make_item(KIND_TOGGLE, 4'd3, 1'b0, 16'd0, 16'd0));
    directed.push_back(make_item(KIND_BLINK_OFF, 4'd2, 1'b0, 16'd0, 16'd0));
    directed.push_back(make_item(KIND_BLINK_ON, 4'd1, 1'b0, 16'd1, 16'd0));
    directed.push_back(make_item(KIND_TICK, 4'd0, 1'b0, 16'd0, 16'd0));
    directed.push_back(make_item(KIND_TICK, 4'd0, 1'b0, 16'd0, 16'd0));
    directed.push_back(make_item(KIND_BLINK_TOGGLE, 4'd1, 1'b0, 16'd1, 16'd0));
    directed.push_back(make_item(KIND_BLINK_TOGGLE, 4'd4, 1'b0, 16'd2, 16'd0));
    directed.push_back(make_item(KIND_BLINK_TIMES, 4'd0, 1'b0, 16'd1, 16'd1));
    directed.push_back(make_item(KIND_TICK, 4'd0, 1'b0, 16'd0, 16'd0));
    directed.push_back(make_item(KIND_TICK, 4'd0, 1'b0, 16'd0, 16'd0));
    directed.push_back(make_item(KIND_BLINK_TIMES, 4'd2, 1'b1, 16'hFFFF, 16'hFFFF));
    directed.push_back(make_item(KIND_BLINK_ON, 4'd3, 1'b0, 16'd0, 16'd1));
    directed.push_back(make_item(KIND_BLINK_TOGGLE, 4'd4, 1'b0, 16'd0, 16'd1));
    directed.push_back(make_item(KIND_BLINK_TIMES, 4'd5, 1'b0, 16'd1, 16'd0));
    directed.push_back(make_item(KIND_SET, 4'(NUM_LEDS), 1'b1, 16'd1, 16'd1));
    directed.push_back(make_item(KIND_TOGGLE, 4'd15, 1'b1, 16'd1, 16'd1));
    directed.push_back(make_item(KIND_UNUSED, 4'd0, 1'b1, 16'd1, 16'd1));
    directed.push_back(make_item(KIND_SET, 4'd2, 1'b1, 16'd0, 16'd0));
    directed.push_back(make_item(KIND_BLINK_TIMES, 4'd5, 1'b0, 16'd3, 16'd2));
    directed.push_back(make_item(KIND_TICK, 4'd0, 1'b0, 16'd0, 16'd0));
    directed.push_back(make_item(KIND_BLINK_OFF, 4'd4, 1'b0, 16'd0, 16'd0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) send_item(directed[i], ok);

    // Receiver idles most, then sender idles most, then back to back
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 58 : 0;
      rx_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 27 : 0;
      taken = 0;
      while (taken < PHASE_BEATS) begin
        if (phase == 1 && taken == PHASE_BEATS / 2) hold_until_drained();
        send_item(random_item(), ok);
        taken++;
      end
    end
    push = 1'b0;

    // Drain, then watch for stray results
    for (int c = 0; c < 20000 && board.pending_levels.size() != 0; c++) @(negedge clk);
    repeat (20) @(negedge clk);
    while (board.pending_levels.size() != 0) begin
      board.flag("expected result never arrived");
      void'(board.pending_levels.pop_front());
    end

    $display("Covered %0d results: %0d ticks, %0d commands, %0d rejected beats.",
             board.checked, board.kind_seen[KIND_TICK],
             board.checked - board.kind_seen[KIND_TICK], board.rejected);
    $display("Ran under sender stalls, receiver stalls and full rate; %0d mismatches.",
             board.mismatches);
    if (board.mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/mlbc_pkg.sv
rtl/core/mlbc_front.sv
rtl/core/mlbc_cmd_q.sv
rtl/core/mlbc_back.sv
rtl/core/multi_led_blink_controller.sv
rtl/core/mlbc_checker.sv
sim/tb_top.sv
